/* rtl/sbe_pkg.sv */
// sbe_pkg: opcodes, status codes, controller states and command structs
// for the stack bytecode executor. No dependencies.
package sbe_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 256;
  localparam int unsigned VAR_COUNT_DEF   = 64;
  localparam int unsigned ADDR_BITS_DEF   = 16;

  typedef enum logic [4:0] {
    OP_HALT = 5'd0, OP_PUSHINT = 5'd1, OP_LOAD = 5'd2, OP_STORE = 5'd3,
    OP_ADD = 5'd4, OP_SUB = 5'd5, OP_MUL = 5'd6, OP_DIV = 5'd7,
    OP_PRINTINT = 5'd8, OP_PRINTSTR = 5'd9, OP_PUSHSTR = 5'd10,
    OP_JMP = 5'd11, OP_JZ = 5'd12, OP_EQ = 5'd13, OP_NE = 5'd14,
    OP_LT = 5'd15, OP_GT = 5'd16, OP_LE = 5'd17, OP_GE = 5'd18
  } opcode_t;

  typedef enum logic [2:0] {
    ST_RUN = 3'd0, ST_HALT = 3'd1, ST_BADOP = 3'd2, ST_STACK = 3'd3,
    ST_DIV0 = 3'd4, ST_BADVAR = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    PK_NONE = 2'd0, PK_INT = 2'd1, PK_STR = 2'd2
  } print_kind_t;

  typedef enum logic [2:0] {
    CS_IDLE, CS_READ, CS_EXEC, CS_DIV, CS_OUT
  } ctrl_state_t;

  // controller -> datapath
  typedef struct packed {
    logic latch_in;   // capture op/arg, launch stack/variable reads
    logic exec;       // evaluate the instruction with read data
    logic div_start;
    logic commit;     // write back a non-divide result; update count, address, stop state
    logic div_commit; // write back the quotient
    logic out_load;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_div;
    logic div_done;
  } dp_stat_t;

endpackage

/* rtl/sbe_divider.sv */
// sbe_divider: 32-bit signed divide, truncating toward zero, one quotient
// bit per cycle. Depends on nothing but its ports.
module sbe_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);
  logic [31:0] rem, quo, dvs;
  logic [5:0]  count;
  logic        neg, busy;
  logic [32:0] trial;

  assign trial = {rem[30:0], quo[31]} - {1'b0, dvs} + 33'd0;
  assign quotient = neg ? (32'd0 - quo) : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= 6'd32;
        rem   <= '0;
        quo   <= dividend[31] ? (32'd0 - dividend) : dividend;
        dvs   <= divisor[31] ? (32'd0 - divisor) : divisor;
        neg   <= dividend[31] ^ divisor[31];
      end else if (busy) begin
        // restoring step: shift in next dividend bit, subtract if it fits
        if (!trial[32]) begin
          rem <= trial[31:0];
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= {rem[30:0], quo[31]};
          quo <= {quo[30:0], 1'b0};
        end
        count <= count - 6'd1;
        if (count == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

/* rtl/sbe_datapath.sv */
// sbe_datapath: operand stack, variable store, instruction address, ALU and
// output register. Depends on sbe_pkg and sbe_divider.
module sbe_datapath #(
  parameter int unsigned STACK_DEPTH = sbe_pkg::STACK_DEPTH_DEF,
  parameter int unsigned VAR_COUNT   = sbe_pkg::VAR_COUNT_DEF,
  parameter int unsigned ADDR_BITS   = sbe_pkg::ADDR_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  sbe_pkg::dp_cmd_t    cmd,
  output sbe_pkg::dp_stat_t   stat,
  input  logic [4:0]          op,
  input  logic signed [31:0]  arg,
  output logic [15:0]         next_addr,
  output logic [1:0]          print_kind,
  output logic signed [31:0]  print_value,
  output logic [2:0]          status
);
  localparam int SP_BITS  = $clog2(STACK_DEPTH);
  localparam int CNT_BITS = $clog2(STACK_DEPTH + 1);
  localparam int VI_BITS  = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;

  logic [31:0] stack_mem [STACK_DEPTH];
  logic [31:0] var_mem [VAR_COUNT];
  logic [VAR_COUNT-1:0] var_valid;

  logic [CNT_BITS-1:0]  stack_count;
  logic [ADDR_BITS-1:0] instr_addr;
  logic                 stopped;
  logic [2:0]           stop_code;

  logic [4:0]  op_q;
  logic [31:0] arg_q;
  logic [31:0] top_q, sec_q, var_q;
  logic        var_v_q;

  // evaluation results held for commit
  logic [2:0]           st_e;
  logic [1:0]           pk_e;
  logic [31:0]          pv_e, res_e;
  logic [ADDR_BITS-1:0] nxt_e;
  logic                 wr_e, vw_e;
  logic [SP_BITS-1:0]   wa_e;
  logic [CNT_BITS-1:0]  cnt_e;
  logic                 div_e;

  logic        var_ok;
  logic [VI_BITS-1:0] vidx;
  logic [SP_BITS-1:0] a1, a2;
  logic [31:0] vval, mul_q;
  logic [31:0] quo;
  logic        ddone;

  // comb evaluation
  logic [2:0]           st_c;
  logic [1:0]           pk_c;
  logic [31:0]          pv_c, res_c;
  logic [ADDR_BITS-1:0] nxt_c;
  logic                 wr_c, vw_c, div_c;
  logic [SP_BITS-1:0]   wa_c;
  logic [CNT_BITS-1:0]  cnt_c;
  logic                 lt_ab, lt_ba;

  assign var_ok = ($unsigned(arg_q) < 32'(VAR_COUNT));
  assign vidx   = VI_BITS'(arg_q);
  assign a1     = SP_BITS'(stack_count - CNT_BITS'(1));
  assign a2     = SP_BITS'(stack_count - CNT_BITS'(2));
  assign vval   = var_v_q ? var_q : 32'd0;
  assign lt_ab  = $signed(sec_q) < $signed(top_q);
  assign lt_ba  = $signed(top_q) < $signed(sec_q);

  sbe_divider u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start),
    .dividend(sec_q), .divisor(top_q), .done(ddone), .quotient(quo)
  );

  assign stat.need_div = div_e;
  assign stat.div_done = ddone;

  always_comb begin
    st_c  = sbe_pkg::ST_RUN;
    pk_c  = sbe_pkg::PK_NONE;
    pv_c  = '0;
    res_c = '0;
    nxt_c = instr_addr + ADDR_BITS'(1);
    wr_c  = 1'b0;
    vw_c  = 1'b0;
    div_c = 1'b0;
    wa_c  = SP_BITS'(stack_count);
    cnt_c = stack_count;
    if (stopped) begin
      st_c  = stop_code;
      nxt_c = instr_addr;
    end else begin
      case (op_q)
        sbe_pkg::OP_HALT: st_c = sbe_pkg::ST_HALT;
        sbe_pkg::OP_PUSHINT, sbe_pkg::OP_PUSHSTR, sbe_pkg::OP_LOAD: begin
          if (op_q == sbe_pkg::OP_LOAD && !var_ok) st_c = sbe_pkg::ST_BADVAR;
          else if (stack_count >= CNT_BITS'(STACK_DEPTH)) st_c = sbe_pkg::ST_STACK;
          else begin
            wr_c  = 1'b1;
            res_c = (op_q == sbe_pkg::OP_LOAD) ? vval : arg_q;
            cnt_c = stack_count + CNT_BITS'(1);
          end
        end
        sbe_pkg::OP_STORE: begin
          if (!var_ok) st_c = sbe_pkg::ST_BADVAR;
          else if (stack_count == '0) st_c = sbe_pkg::ST_STACK;
          else begin
            vw_c  = 1'b1;
            res_c = top_q;
            cnt_c = stack_count - CNT_BITS'(1);
          end
        end
        sbe_pkg::OP_PRINTINT, sbe_pkg::OP_PRINTSTR: begin
          if (stack_count == '0) st_c = sbe_pkg::ST_STACK;
          else begin
            pv_c  = top_q;
            pk_c  = (op_q == sbe_pkg::OP_PRINTINT) ? sbe_pkg::PK_INT : sbe_pkg::PK_STR;
            cnt_c = stack_count - CNT_BITS'(1);
          end
        end
        sbe_pkg::OP_JMP: nxt_c = ADDR_BITS'(arg_q);
        sbe_pkg::OP_JZ: begin
          if (stack_count == '0) st_c = sbe_pkg::ST_STACK;
          else begin
            cnt_c = stack_count - CNT_BITS'(1);
            if (top_q == '0) nxt_c = ADDR_BITS'(arg_q);
          end
        end
        sbe_pkg::OP_ADD, sbe_pkg::OP_SUB, sbe_pkg::OP_MUL, sbe_pkg::OP_DIV,
        sbe_pkg::OP_EQ, sbe_pkg::OP_NE, sbe_pkg::OP_LT, sbe_pkg::OP_GT,
        sbe_pkg::OP_LE, sbe_pkg::OP_GE: begin
          if (stack_count < CNT_BITS'(2)) st_c = sbe_pkg::ST_STACK;
          else if (op_q == sbe_pkg::OP_DIV && top_q == '0) st_c = sbe_pkg::ST_DIV0;
          else begin
            wr_c  = 1'b1;
            wa_c  = a2;
            cnt_c = stack_count - CNT_BITS'(1);
            case (op_q)
              sbe_pkg::OP_ADD: res_c = sec_q + top_q;
              sbe_pkg::OP_SUB: res_c = sec_q - top_q;
              sbe_pkg::OP_MUL: res_c = mul_q;
              sbe_pkg::OP_DIV: div_c = 1'b1;
              sbe_pkg::OP_EQ:  res_c = {31'd0, sec_q == top_q};
              sbe_pkg::OP_NE:  res_c = {31'd0, sec_q != top_q};
              sbe_pkg::OP_LT:  res_c = {31'd0, lt_ab};
              sbe_pkg::OP_GT:  res_c = {31'd0, lt_ba};
              sbe_pkg::OP_LE:  res_c = {31'd0, !lt_ba};
              default:         res_c = {31'd0, !lt_ab};
            endcase
          end
        end
        default: st_c = sbe_pkg::ST_BADOP;
      endcase
      if (st_c != sbe_pkg::ST_RUN) nxt_c = instr_addr;
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      top_q <= stack_mem[a1];
      sec_q <= stack_mem[a2];
    end
    if ((cmd.commit && wr_e && !div_e) || cmd.div_commit)
      stack_mem[wa_e] <= cmd.div_commit ? quo : res_e;
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) var_q <= var_mem[VI_BITS'(arg)];
    if (cmd.commit && vw_e) var_mem[vidx] <= res_e;
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_q  <= op;
      arg_q <= arg;
    end
    if (cmd.latch_in) var_v_q <= var_valid[VI_BITS'(arg)];
    mul_q <= sec_q * top_q;
    if (cmd.exec) begin
      st_e <= st_c; pk_e <= pk_c; pv_e <= pv_c; res_e <= res_c;
      nxt_e <= nxt_c; wa_e <= wa_c; cnt_e <= cnt_c;
    end
    if (cmd.out_load) begin
      next_addr   <= 16'(nxt_e);
      print_kind  <= pk_e;
      print_value <= pv_e;
      status      <= st_e;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stack_count <= '0;
      instr_addr  <= '0;
      stopped     <= 1'b0;
      stop_code   <= sbe_pkg::ST_RUN;
      var_valid   <= '0;
      wr_e <= 1'b0; vw_e <= 1'b0; div_e <= 1'b0;
    end else begin
      if (cmd.exec) begin
        wr_e <= wr_c; vw_e <= vw_c; div_e <= div_c;
      end
      if (cmd.commit) begin
        stack_count <= cnt_e;
        instr_addr  <= nxt_e;
        if (vw_e) var_valid[vidx] <= 1'b1;
        if (!stopped && st_e != sbe_pkg::ST_RUN) begin
          stopped   <= 1'b1;
          stop_code <= st_e;
        end
      end
    end
  end
endmodule

/* rtl/sbe_controller.sv */
// sbe_controller: sequences each instruction through read, execute and
// output, then a divide through the divider. Depends on sbe_pkg.
module sbe_controller (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  sbe_pkg::dp_stat_t  stat,
  output sbe_pkg::dp_cmd_t   cmd
);
  sbe_pkg::ctrl_state_t state, state_next;
  logic out_full, out_full_next;

  always_comb begin
    state_next = state;
    case (state)
      sbe_pkg::CS_IDLE: if (in_valid) state_next = sbe_pkg::CS_READ;
      sbe_pkg::CS_READ: state_next = sbe_pkg::CS_EXEC;
      sbe_pkg::CS_EXEC: state_next = sbe_pkg::CS_OUT;
      // result already went out, only the quotient write-back remains
      sbe_pkg::CS_DIV:  if (stat.div_done) state_next = sbe_pkg::CS_IDLE;
      sbe_pkg::CS_OUT: begin
        // wait for the previous result to drain
        if (!out_full || !out_stall) begin
          if (stat.need_div) state_next = sbe_pkg::CS_DIV;
          else state_next = sbe_pkg::CS_IDLE;
        end
      end
      default: state_next = sbe_pkg::CS_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = (state != sbe_pkg::CS_IDLE);
    out_full_next = out_full && out_stall;
    case (state)
      sbe_pkg::CS_IDLE: cmd.latch_in = in_valid;
      sbe_pkg::CS_EXEC: cmd.exec = 1'b1;
      sbe_pkg::CS_DIV: if (stat.div_done) cmd.div_commit = 1'b1;
      sbe_pkg::CS_OUT: begin
        if (!out_full || !out_stall) begin
          cmd.commit    = 1'b1;
          cmd.div_start = stat.need_div;
          cmd.out_load  = 1'b1;
          out_full_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= sbe_pkg::CS_IDLE;
      out_full <= 1'b0;
    end else begin
      state    <= state_next;
      out_full <= out_full_next;
    end
  end
endmodule

/* rtl/stack_bytecode_executor_unit.sv */
// Stack bytecode executor: one instruction per input transaction, one result
// transaction each. Each instruction goes through stack read, evaluate and
// result register, and no new instruction is accepted until the block is idle
// again; a divide keeps the block busy in the bit-serial divider after its
// result goes out, until its quotient is written.
// The result register holds a finished result while the next is fetched.
// After halt or any fault, the block repeats the stop status until reset.
module stack_bytecode_executor_unit #(
  parameter int unsigned STACK_DEPTH = sbe_pkg::STACK_DEPTH_DEF,
  parameter int unsigned VAR_COUNT   = sbe_pkg::VAR_COUNT_DEF,
  parameter int unsigned ADDR_BITS   = sbe_pkg::ADDR_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [4:0]         op,
  input  logic signed [31:0] arg,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        next_addr,
  output logic [1:0]         print_kind,
  output logic signed [31:0] print_value,
  output logic [2:0]         status
);
  sbe_pkg::dp_cmd_t  cmd;
  sbe_pkg::dp_stat_t stat;

  sbe_controller u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .stat(stat), .cmd(cmd)
  );

  sbe_datapath #(
    .STACK_DEPTH(STACK_DEPTH), .VAR_COUNT(VAR_COUNT), .ADDR_BITS(ADDR_BITS)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat), .op(op), .arg(arg),
    .next_addr(next_addr), .print_kind(print_kind), .print_value(print_value),
    .status(status)
  );

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.latch_in |=> in_stall) else $error("accepted while busy");

  a_kind_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && print_kind == sbe_pkg::PK_NONE |-> print_value == 32'd0)
    else $error("print value without kind");

  a_print_running: assert property (@(posedge clk) disable iff (rst)
    out_valid && print_kind != sbe_pkg::PK_NONE |-> status == sbe_pkg::ST_RUN)
    else $error("print on stopped instruction");
endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// testbench: self-checking bench for stack_bytecode_executor_unit, driving
// instruction streams and comparing every result against an in-bench predictor.
// Depends on sbe_pkg and the executor RTL.
module testbench;

  localparam int STK_MAX = sbe_pkg::STACK_DEPTH_DEF;
  localparam int VARS = sbe_pkg::VAR_COUNT_DEF;
  localparam int N_RANDOM = 1200;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic [4:0]  op;
    logic [31:0] arg;
  } instr_t;

  typedef struct packed {
    logic [15:0] next_addr;
    logic [1:0]  kind;
    logic [31:0] value;
    logic [2:0]  st;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [4:0] op = '0;
  logic signed [31:0] arg = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [15:0] next_addr;
  logic [1:0] print_kind;
  logic signed [31:0] print_value;
  logic [2:0] status;

  stack_bytecode_executor_unit u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .op(op), .arg(arg),
    .out_valid(out_valid), .out_stall(out_stall),
    .next_addr(next_addr), .print_kind(print_kind), .print_value(print_value),
    .status(status)
  );

  initial forever #5 clk = ~clk;

  instr_t   program_q[$];
  outcome_t outcome_q[$];
  int gen_depth = 0;
  int n_total = 0;
  int n_issued = 0;
  int n_done = 0;
  int n_prints = 0;
  int n_divs = 0;
  int errors = 0;
  int cycles = 0;
  bit took = 1'b0;

  // executor state as the bench sees it
  logic [31:0]      stk [STK_MAX];
  logic [31:0]      vars [VARS];
  int               sp = 0;
  logic [15:0]      pc = '0;
  bit               halted = 1'b0;
  sbe_pkg::status_t stop_code = sbe_pkg::ST_RUN;

  function automatic int depth_change(sbe_pkg::opcode_t o);
    case (o)
      sbe_pkg::OP_PUSHINT, sbe_pkg::OP_PUSHSTR, sbe_pkg::OP_LOAD: return 1;
      sbe_pkg::OP_STORE, sbe_pkg::OP_PRINTINT, sbe_pkg::OP_PRINTSTR,
      sbe_pkg::OP_JZ: return -1;
      sbe_pkg::OP_JMP, sbe_pkg::OP_HALT: return 0;
      default: return -1;
    endcase
  endfunction

  task automatic emit(sbe_pkg::opcode_t o, logic [31:0] a);
    program_q.push_back('{op: o, arg: a});
    gen_depth += depth_change(o);
    n_total++;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h0;
      1: return 32'h1;
      2: return 32'hFFFF_FFFF;
      3: return 32'h8000_0000;
      4: return 32'h7FFF_FFFF;
      5: return $urandom_range(0, 20) - 10;
      default: return $urandom;
    endcase
  endfunction

  function automatic sbe_pkg::opcode_t pick_binary();
    sbe_pkg::opcode_t b [10] = '{sbe_pkg::OP_ADD, sbe_pkg::OP_SUB, sbe_pkg::OP_MUL,
                                 sbe_pkg::OP_EQ, sbe_pkg::OP_NE, sbe_pkg::OP_LT,
                                 sbe_pkg::OP_GT, sbe_pkg::OP_LE, sbe_pkg::OP_GE,
                                 sbe_pkg::OP_ADD};
    return b[$urandom_range(0, 9)];
  endfunction

  // one well-formed instruction (or a push and divide pair) chosen to keep the stack in range
  task automatic emit_random();
    int pick;
    pick = $urandom_range(0, 99);
    if (gen_depth < 2 && pick >= 45) pick = $urandom_range(0, 44);
    if (gen_depth >= STK_MAX - 2 && pick < 35) pick = 60;
    if (pick < 25)
      emit($urandom_range(0, 1) ? sbe_pkg::OP_PUSHINT : sbe_pkg::OP_PUSHSTR, pick_value());
    else if (pick < 35)
      emit(sbe_pkg::OP_LOAD, $urandom_range(0, VARS - 1));
    else if (pick < 45)
      emit(sbe_pkg::OP_JMP, $urandom);
    else if (pick < 52)
      emit(sbe_pkg::OP_STORE, $urandom_range(0, VARS - 1));
    else if (pick < 60)
      emit($urandom_range(0, 1) ? sbe_pkg::OP_PRINTINT : sbe_pkg::OP_PRINTSTR, $urandom);
    else if (pick < 65)
      emit(sbe_pkg::OP_JZ, $urandom);
    else if (pick < 72) begin
      logic [31:0] d;
      d = pick_value();
      if (d == 0) d = 32'd3;
      emit(sbe_pkg::OP_PUSHINT, d);
      emit(sbe_pkg::OP_DIV, $urandom);
    end else
      emit(pick_binary(), $urandom);
  endtask

  task automatic work_out(logic [4:0] o, logic [31:0] a);
    outcome_t e;
    logic [31:0] x, y, r;
    sbe_pkg::status_t s;
    s = sbe_pkg::ST_RUN;
    e = '0;
    e.next_addr = pc + 16'd1;
    if (halted) begin
      s = stop_code;
      e.next_addr = pc;
    end else begin
      case (o)
        sbe_pkg::OP_HALT: s = sbe_pkg::ST_HALT;
        sbe_pkg::OP_PUSHINT, sbe_pkg::OP_PUSHSTR:
          if (sp >= STK_MAX) s = sbe_pkg::ST_STACK;
          else begin stk[sp] = a; sp++; end
        sbe_pkg::OP_LOAD:
          if (a >= VARS) s = sbe_pkg::ST_BADVAR;
          else if (sp >= STK_MAX) s = sbe_pkg::ST_STACK;
          else begin stk[sp] = vars[a]; sp++; end
        sbe_pkg::OP_STORE:
          if (a >= VARS) s = sbe_pkg::ST_BADVAR;
          else if (sp < 1) s = sbe_pkg::ST_STACK;
          else begin sp--; vars[a] = stk[sp]; end
        sbe_pkg::OP_PRINTINT, sbe_pkg::OP_PRINTSTR:
          if (sp < 1) s = sbe_pkg::ST_STACK;
          else begin
            sp--;
            e.value = stk[sp];
            e.kind = (o == sbe_pkg::OP_PRINTINT) ? sbe_pkg::PK_INT : sbe_pkg::PK_STR;
            n_prints++;
          end
        sbe_pkg::OP_JMP: e.next_addr = a[15:0];
        sbe_pkg::OP_JZ:
          if (sp < 1) s = sbe_pkg::ST_STACK;
          else begin
            sp--;
            if (stk[sp] == 0) e.next_addr = a[15:0];
          end
        sbe_pkg::OP_ADD, sbe_pkg::OP_SUB, sbe_pkg::OP_MUL, sbe_pkg::OP_DIV,
        sbe_pkg::OP_EQ, sbe_pkg::OP_NE, sbe_pkg::OP_LT, sbe_pkg::OP_GT,
        sbe_pkg::OP_LE, sbe_pkg::OP_GE:
          if (sp < 2) s = sbe_pkg::ST_STACK;
          else begin
            y = stk[sp - 1];
            x = stk[sp - 2];
            if (o == sbe_pkg::OP_DIV && y == 0) s = sbe_pkg::ST_DIV0;
            else begin
              case (o)
                sbe_pkg::OP_ADD: r = x + y;
                sbe_pkg::OP_SUB: r = x - y;
                sbe_pkg::OP_MUL: r = x * y;
                sbe_pkg::OP_DIV: begin
                  n_divs++;
                  // most negative over minus one wraps to itself
                  if (x == 32'h8000_0000 && y == 32'hFFFF_FFFF) r = x;
                  else r = $signed(x) / $signed(y);
                end
                sbe_pkg::OP_EQ: r = {31'd0, x == y};
                sbe_pkg::OP_NE: r = {31'd0, x != y};
                sbe_pkg::OP_LT: r = {31'd0, $signed(x) < $signed(y)};
                sbe_pkg::OP_GT: r = {31'd0, $signed(x) > $signed(y)};
                sbe_pkg::OP_LE: r = {31'd0, $signed(x) <= $signed(y)};
                default: r = {31'd0, $signed(x) >= $signed(y)};
              endcase
              sp--;
              stk[sp - 1] = r;
            end
          end
        default: s = sbe_pkg::ST_BADOP;
      endcase
      if (s != sbe_pkg::ST_RUN) begin
        halted = 1'b1;
        stop_code = s;
        e.next_addr = pc;
      end else
        pc = e.next_addr;
    end
    e.st = s;
    outcome_q.push_back(e);
  endtask

  // accepted transactions on both sides, sampled at the rising edge
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end else if (!rst) begin
      took = in_valid && !in_stall;
      if (took) work_out(op, arg);
      if (out_valid && !out_stall) begin
        n_done++;
        if (outcome_q.size() == 0) begin
          $error("result with nothing expected: next_addr %0d status %0d", next_addr, status);
          errors++;
        end else begin
          outcome_t e;
          e = outcome_q.pop_front();
          if (next_addr !== e.next_addr) begin
            $error("next_addr expected %0d actual %0d", e.next_addr, next_addr);
            errors++;
          end
          if (print_kind !== e.kind) begin
            $error("print_kind expected %0d actual %0d", e.kind, print_kind);
            errors++;
          end
          if (print_value !== e.value) begin
            $error("print_value expected %0h actual %0h", e.value, print_value);
            errors++;
          end
          if (status !== e.st) begin
            $error("status expected %0d actual %0d", e.st, status);
            errors++;
          end
        end
      end
    end
  end

  // idling profile moves through three phases over the run
  always @(negedge clk) begin
    int phase;
    phase = (n_total == 0) ? 0 : (n_issued * 3) / n_total;
    if (!rst) begin
      if (!in_valid || took) begin
        if (program_q.size() > 0 &&
            $urandom_range(0, 99) >= (phase == 0 ? 13 : (phase == 1 ? 86 : 0))) begin
          instr_t it;
          it = program_q.pop_front();
          op <= it.op;
          arg <= it.arg;
          in_valid <= 1'b1;
          n_issued++;
        end else
          in_valid <= 1'b0;
      end
      out_stall <= $urandom_range(0, 99) < (phase == 0 ? 86 : (phase == 1 ? 13 : 0));
    end
  end

  initial begin
    int kind;
    for (int i = 0; i < VARS; i++) vars[i] = '0;
    // directed: operand extremes, every operation but halt, divide corner cases
    emit(sbe_pkg::OP_PUSHINT, 32'h7FFF_FFFF);
    emit(sbe_pkg::OP_PUSHINT, 32'h8000_0000);
    emit(sbe_pkg::OP_SUB, 0);
    emit(sbe_pkg::OP_PRINTINT, 0);
    emit(sbe_pkg::OP_PUSHINT, 7);
    emit(sbe_pkg::OP_PUSHINT, 32'hFFFF_FFFE);
    emit(sbe_pkg::OP_DIV, 0);
    emit(sbe_pkg::OP_PRINTSTR, 0);
    emit(sbe_pkg::OP_PUSHINT, 32'h8000_0000);
    emit(sbe_pkg::OP_PUSHINT, 32'hFFFF_FFFF);
    emit(sbe_pkg::OP_DIV, 0);
    emit(sbe_pkg::OP_PUSHSTR, 5);
    emit(sbe_pkg::OP_MUL, 0);
    emit(sbe_pkg::OP_STORE, VARS - 1);
    emit(sbe_pkg::OP_LOAD, VARS - 1);
    emit(sbe_pkg::OP_LOAD, 0);
    emit(sbe_pkg::OP_EQ, 0);
    emit(sbe_pkg::OP_PUSHINT, 3);
    emit(sbe_pkg::OP_NE, 0);
    emit(sbe_pkg::OP_PUSHINT, 32'hFFFF_FFFF);
    emit(sbe_pkg::OP_LT, 0);
    emit(sbe_pkg::OP_PUSHINT, 1);
    emit(sbe_pkg::OP_GT, 0);
    emit(sbe_pkg::OP_PUSHINT, 0);
    emit(sbe_pkg::OP_LE, 0);
    emit(sbe_pkg::OP_PUSHINT, 0);
    emit(sbe_pkg::OP_GE, 0);
    emit(sbe_pkg::OP_PUSHINT, 32'hFFFF_FFFF);
    emit(sbe_pkg::OP_ADD, 0);
    emit(sbe_pkg::OP_JZ, 32'h0001_1234);
    emit(sbe_pkg::OP_JMP, 32'hFFFF_FFF0);
    for (int i = 0; i < N_RANDOM; i++) begin
      emit_random();
      // one run right up to a full stack and back
      if (i == N_RANDOM / 2) begin
        while (gen_depth < STK_MAX) emit(sbe_pkg::OP_PUSHINT, $urandom);
        while (gen_depth > 8) emit(sbe_pkg::OP_PRINTINT, 0);
      end
    end
    // a single stopping event, since reset is applied only once
    kind = $urandom_range(0, 5);
    case (kind)
      0: emit(sbe_pkg::OP_HALT, $urandom);
      1: emit(sbe_pkg::opcode_t'($urandom_range(19, 31)), $urandom);
      2: begin
        while (gen_depth > 0) emit(sbe_pkg::OP_PRINTSTR, 0);
        emit($urandom_range(0, 1) ? sbe_pkg::OP_ADD : sbe_pkg::OP_JZ, 0);
      end
      3: begin
        while (gen_depth < STK_MAX) emit(sbe_pkg::OP_PUSHINT, $urandom);
        emit(sbe_pkg::OP_LOAD, 1);
      end
      4: begin
        if (gen_depth < 1) emit(sbe_pkg::OP_PUSHINT, 9);
        emit(sbe_pkg::OP_PUSHINT, 0);
        emit(sbe_pkg::OP_DIV, 0);
      end
      default: emit($urandom_range(0, 1) ? sbe_pkg::OP_LOAD : sbe_pkg::OP_STORE,
                    $urandom_range(0, 1) ? 32'h8000_0000 + $urandom_range(0, 99) : VARS);
    endcase
    for (int i = 0; i < 6; i++) emit(sbe_pkg::opcode_t'($urandom_range(0, 31)), $urandom);

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    while (program_q.size() > 0 || in_valid || outcome_q.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (outcome_q.size() > 0) begin
      $error("%0d results never arrived", outcome_q.size());
      errors++;
    end
    $display("ran %0d instructions (%0d prints, %0d divides), %0d results checked",
             n_issued, n_prints, n_divs, n_done);
    $display("block stopped with status %0d, %0d mismatches", stop_code, errors);
    if (errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

/* stack_bytecode_executor_unit.f */
rtl/sbe_pkg.sv
rtl/sbe_divider.sv
rtl/sbe_datapath.sv
rtl/sbe_controller.sv
rtl/stack_bytecode_executor_unit.sv
tb/sv/testbench.sv
